/* rtl/table_linear_interpolator_unit_macros.svh */
// Assertion macros used by the interpolator checker.
`ifndef TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define TLI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("interpolator check failed");

// Next-cycle implication, quiet while reset is held.
`define TLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("interpolator check failed");

`endif

/* rtl/tli_pkg.sv */
// Types and constants of the table linear interpolator.
`default_nettype none

package tli_pkg;

    localparam int DW   = 32;   // key and value width
    localparam int IDXW = 11;   // entry index field width
    localparam int CNTW = 12;   // entries_in_use register width
    localparam int CFGW = 2;    // configuration index width

    localparam logic [CFGW-1:0] CFG_ENTRIES   = 2'd0;
    localparam logic [CFGW-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFGW-1:0] CFG_UPPER     = 2'd2;

    localparam logic [CNTW-1:0] ENTRIES_RESET = 12'd2000;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        t_func             func;
        logic [IDXW-1:0]   entry_index;
        logic [DW-1:0]     key;
        logic [DW-1:0]     entry_value;
    } t_item;

    typedef struct packed {
        logic [DW-1:0]     result_value;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic [DW-1:0]     key;
        logic [DW-1:0]     value;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/table_linear_interpolator_unit.sv */
// Piecewise linear table interpolator: table memory, linear search and serial divider.
//
//  channel   | direction | handshake                       | payload
//  ----------+-----------+---------------------------------+------------------------------
//  command   | in        | start, busy (beat: start & !busy) | i_item (t_item)
//  result    | out       | o_done, one cycle, no back-pressure | o_result (t_result)
//  config    | in        | i_cfg_valid, o_cfg_ready (always 1) | i_cfg_index, i_cfg_data
//
// A write, or a query settled by the limits, gives its result in the cycle after the beat.
// An interpolated query reads one table entry a cycle until the first key above the query
// key, entry m, then passes through a multiply state and 32 divider steps.
// The scan of the table memory and the bit-serial divider set how long a query takes.
// Reset is synchronous and needs no clearing pass; the table is undefined until written.
// Commands are taken one at a time while busy is low; results cannot be stalled.
`default_nettype none

module table_linear_interpolator_unit
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 2048
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire t_item            i_item,
    output      logic             o_done,
    output      t_result          o_result,
    input  wire logic             i_cfg_valid,
    output      logic             o_cfg_ready,
    input  wire logic [CFGW-1:0]  i_cfg_index,
    input  wire logic [DW-1:0]    i_cfg_data
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = AW + 1;
    localparam int DCW = $clog2(DW);

    // table memory
    t_entry              mem [TABLE_DEPTH];
    t_entry              r_rdata;

    // configuration
    logic [CNTW-1:0]     r_entries;
    logic [DW-1:0]       r_thr;
    logic [DW-1:0]       r_upper;

    // control and datapath
    t_state              r_state, n_state;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_dv, n_dv;
    logic [CW-1:0]       r_didx, n_didx;
    t_entry              r_prev, n_prev;
    logic [DW-1:0]       r_key, n_key;
    logic [DW-1:0]       r_a, n_a;
    logic [DW-1:0]       r_b, n_b;
    logic [DW-1:0]       r_d, n_d;
    logic [DW-1:0]       r_v0, n_v0;
    logic                r_neg, n_neg;
    logic [DW-1:0]       r_rem, n_rem;
    logic [DW-1:0]       r_quo, n_quo;
    logic [DCW-1:0]      r_cnt, n_cnt;
    logic                r_done, n_done;
    t_result             r_res, n_res;

    logic                w_accept;
    logic                w_query;
    logic [31:0]         w_eiu32;
    logic [31:0]         w_count32;
    logic [CW-1:0]       w_count;
    logic                w_few;
    logic                w_early;
    logic [31:0]         w_widx32;
    logic                w_mem_we;
    logic [AW-1:0]       w_waddr;
    logic                w_hit;
    logic                w_last;
    logic [2*DW-1:0]     w_prod;
    logic [DW:0]         w_trial;
    logic [DW:0]         w_diff;
    logic                w_ge;

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    assign w_accept  = start && !busy;
    assign w_query   = (i_item.func == FUNC_QUERY);

    // clamp the searched count to the table depth
    assign w_eiu32   = 32'(r_entries);
    assign w_count32 = (w_eiu32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : w_eiu32;
    assign w_count   = w_count32[CW-1:0];
    assign w_few     = (w_count32 < 32'd2);
    assign w_early   = (i_item.key > r_upper) || (i_item.key <= r_thr) || w_few;

    assign w_widx32  = 32'(i_item.entry_index);
    assign w_waddr   = w_widx32[AW-1:0];
    assign w_mem_we  = w_accept && !w_query && (w_widx32 < 32'(TABLE_DEPTH));

    assign w_hit     = r_dv && (r_rdata.key > r_key);
    assign w_last    = r_dv && (r_didx == (w_count - CW'(1)));

    assign w_prod    = {{DW{1'b0}}, r_a} * {{DW{1'b0}}, r_b};
    assign w_trial   = {r_rem, r_quo[DW-1]};
    assign w_diff    = w_trial - {1'b0, r_d};
    assign w_ge      = (w_trial >= {1'b0, r_d});

    // Writes land only while idle and reads matter only during the scan,
    // so the two never meet on one entry.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_waddr] <= '{key: i_item.key, value: i_item.entry_value};
        end
        r_rdata <= mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
            r_thr     <= '0;
            r_upper   <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENTRIES:   r_entries <= i_cfg_data[CNTW-1:0];
                CFG_THRESHOLD: r_thr     <= i_cfg_data;
                CFG_UPPER:     r_upper   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_query && !w_early) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_didx == '0) ? S_IDLE : S_MUL;
                end else if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DCW'(DW - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_addr = r_addr;
        n_dv   = 1'b0;
        n_didx = r_didx;
        n_prev = r_prev;
        n_key  = r_key;
        n_a    = r_a;
        n_b    = r_b;
        n_d    = r_d;
        n_v0   = r_v0;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_res  = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key  = i_item.key;
                    n_addr = '0;
                    if (!w_query) begin
                        n_done = 1'b1;
                        n_res  = '{result_value: '0, status: ST_OK};
                    end else if (i_item.key > r_upper) begin
                        n_done = 1'b1;
                        n_res  = '{result_value: '0, status: ST_RANGE};
                    end else if (i_item.key <= r_thr) begin
                        n_done = 1'b1;
                        n_res  = '{result_value: '0, status: ST_ZERO};
                    end else if (w_few) begin
                        n_done = 1'b1;
                        n_res  = '{result_value: '0, status: ST_RANGE};
                    end
                end
            end
            S_SCAN: begin
                // issue the next read while the previous one is checked
                if (r_addr < w_count) begin
                    n_dv   = 1'b1;
                    n_didx = r_addr;
                    n_addr = r_addr + CW'(1);
                end
                if (w_hit) begin
                    if (r_didx == '0) begin
                        n_done = 1'b1;
                        n_res  = '{result_value: '0, status: ST_RANGE};
                    end else begin
                        n_a   = r_key - r_prev.key;
                        n_d   = r_rdata.key - r_prev.key;
                        n_v0  = r_prev.value;
                        n_neg = (r_rdata.value < r_prev.value);
                        n_b   = (r_rdata.value < r_prev.value) ?
                                (r_prev.value - r_rdata.value) :
                                (r_rdata.value - r_prev.value);
                    end
                end else if (r_dv) begin
                    n_prev = r_rdata;
                    if (w_last) begin
                        n_done = 1'b1;
                        n_res  = '{result_value: '0, status: ST_RANGE};
                    end
                end
            end
            S_MUL: begin
                // high half is below the divisor, so it seeds the remainder
                n_rem = w_prod[2*DW-1:DW];
                n_quo = w_prod[DW-1:0];
                n_cnt = '0;
            end
            S_DIV: begin
                n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                n_quo = {r_quo[DW-2:0], w_ge};
                n_cnt = r_cnt + DCW'(1);
            end
            S_FIN: begin
                n_done = 1'b1;
                n_res  = '{result_value: (r_neg ? (r_v0 - r_quo) : (r_v0 + r_quo)),
                           status: ST_OK};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_didx <= n_didx;
        r_prev <= n_prev;
        r_key  <= n_key;
        r_a    <= n_a;
        r_b    <= n_b;
        r_d    <= n_d;
        r_v0   <= n_v0;
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

endmodule

`default_nettype wire

/* rtl/tli_checker.sv */
// Port-level checks of the interpolator and their bind to the top level.
`default_nettype none

`include "table_linear_interpolator_unit_macros.svh"

module tli_checker
    import tli_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire t_item   i_item,
    input wire logic    o_done,
    input wire t_result o_result
);

    // a write beat answers in the very next cycle
    `TLI_ASSERT_NEXT(a_write_answers, i_clk, i_rst_n, start && !busy && (i_item.func == FUNC_WRITE), o_done)

    // a result beat follows either a command beat or a busy cycle
    `TLI_ASSERT_NOW(a_done_has_cause, i_clk, i_rst_n, o_done && $past(i_rst_n), $past(start) || $past(busy))

    // the block is free again when a result leaves
    `TLI_ASSERT_NOW(a_done_when_idle, i_clk, i_rst_n, o_done, !busy)

    // only an ok status carries a non-zero value
    `TLI_ASSERT_NOW(a_status_value, i_clk, i_rst_n, o_done && (o_result.status != ST_OK), o_result.result_value == '0)

endmodule

bind table_linear_interpolator_unit tli_checker u_tli_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
